FILE: hw/rtl/rgb_led_fade_controller_unit_defines.svh
// Assertion macros for the RGB LED fade controller.
`ifndef RGB_LED_FADE_CONTROLLER_UNIT_DEFINES_SVH
`define RGB_LED_FADE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RLF_ASSERT_IMPL(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("rlf assertion failed");
// Next-cycle implication, disabled during reset.
`define RLF_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("rlf assertion failed");
`else
`define RLF_ASSERT_IMPL(label, clock, reset, ante, cons)
`define RLF_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

FILE: hw/rtl/rlf_pkg.sv
// Types and constants shared by the RGB LED fade controller.
package rlf_pkg;

  localparam int RLF_CHANNELS     = 3;
  localparam int RLF_MAX_CHANNELS = 3;

  // Transaction kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Button bit positions
  localparam int BTN_MODE   = 0;
  localparam int BTN_CHANGE = 1;

  localparam logic [7:0] LEVEL_FULL  = 8'hFF;
  localparam logic [7:0] LEVEL_OFF   = 8'h00;
  localparam logic [1:0] SPEED_LAST  = 2'd2;
  localparam logic [2:0] COLOR_FIRST = 3'd1;
  localparam logic [2:0] COLOR_LAST  = 3'd7;
  localparam logic [1:0] BTN_IDLE    = 2'b11;

  typedef struct packed {
    logic       kind;
    logic [1:0] buttons;
    logic [2:0] random_pick;
  } rlf_item_t;

  typedef struct packed {
    logic [2:0] led_pins;
    logic       solid_mode;
    logic [2:0] color_index;
    logic [7:0] speed_delay;
    logic [1:0] blink_count;
  } rlf_result_t;

endpackage

FILE: hw/rtl/rgb_led_fade_controller_unit.sv
// Top level of the RGB LED fade controller: state, step logic and output buffer.
`include "rgb_led_fade_controller_unit_defines.svh"

// Takes one transaction per clock while item_ready is high: a pwm tick or a
// main loop step. Each transaction is worked by the combinational logic
// between the input handshake and the result register (or the skid register
// while a result waits), so items can be accepted back to back. A two-entry
// output buffer (result register plus skid register) lets the block keep
// accepting while a result waits; item_ready drops only while both entries
// are full. There is no clearing pass: the block is ready right after reset.
module rgb_led_fade_controller_unit #(
  parameter int CHANNELS = rlf_pkg::RLF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rlf_pkg::rlf_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output rlf_pkg::rlf_result_t result
);
  import rlf_pkg::*;

  // Controller state
  logic [7:0]          pwm_counter, pwm_counter_next;
  logic [7:0]          level [CHANNELS];
  logic [7:0]          level_next [CHANNELS];
  logic [CHANNELS-1:0] target_on, target_on_next;
  logic                mode_bit, mode_bit_next;
  logic [2:0]          solid_color, solid_color_next;
  logic [1:0]          speed_level, speed_level_next;
  logic [1:0]          prev_buttons, prev_buttons_next;
  logic [2:0]          pin_reg, pin_reg_next;
  logic [1:0]          blinks;

  // Output buffer
  rlf_result_t         skid;
  logic                skid_valid;
  rlf_result_t         fresh;

  logic                accept;
  logic                pop;
  logic [1:0]          fell;
  logic [2:0]          pick_inc;
  logic                all_done;

  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign pop        = result_valid && result_ready;
  assign pick_inc   = item.random_pick + 3'd1;
  assign fell       = prev_buttons & ~item.buttons;

  // Next state for one transaction
  always_comb begin
    pwm_counter_next  = pwm_counter;
    level_next        = level;
    target_on_next    = target_on;
    mode_bit_next     = mode_bit;
    solid_color_next  = solid_color;
    speed_level_next  = speed_level;
    prev_buttons_next = prev_buttons;
    pin_reg_next      = pin_reg;
    blinks            = 2'd0;
    all_done          = 1'b1;

    if (item.kind == KIND_TICK) begin
      pwm_counter_next = pwm_counter + 8'd1;
      pin_reg_next     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pin_reg_next[i] = (level[i] <= pwm_counter_next);
      end
    end else begin
      // fade: step toward target, pick new targets once all arrived
      if (!mode_bit) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (level[i] != (target_on[i] ? LEVEL_FULL : LEVEL_OFF)) begin
            all_done = 1'b0;
            if (target_on[i]) level_next[i] = level[i] + 8'd1;
            else              level_next[i] = level[i] - 8'd1;
          end
        end
        if (all_done) target_on_next = pick_inc[CHANNELS-1:0];
      end

      prev_buttons_next = item.buttons;

      // mode button: toggle, load levels when entering solid mode
      if (fell[BTN_MODE]) begin
        mode_bit_next = !mode_bit;
        if (!mode_bit) begin
          for (int i = 0; i < CHANNELS; i++) begin
            level_next[i] = solid_color[i] ? LEVEL_OFF : LEVEL_FULL;
          end
        end
      end

      // change button acts on the updated mode
      if (fell[BTN_CHANGE]) begin
        if (!mode_bit_next) begin
          speed_level_next = (speed_level == SPEED_LAST) ? 2'd0 : speed_level + 2'd1;
          blinks           = speed_level_next + 2'd1;
        end else begin
          solid_color_next = (solid_color == COLOR_LAST) ? COLOR_FIRST
                                                         : solid_color + 3'd1;
          for (int i = 0; i < CHANNELS; i++) begin
            level_next[i] = solid_color_next[i] ? LEVEL_OFF : LEVEL_FULL;
          end
        end
      end
    end
  end

  // Result of this transaction
  always_comb begin
    fresh.led_pins    = pin_reg_next;
    fresh.solid_mode  = mode_bit_next;
    fresh.color_index = solid_color_next;
    fresh.speed_delay = {speed_level_next, 6'd0};
    fresh.blink_count = blinks;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter  <= '0;
      for (int i = 0; i < CHANNELS; i++) level[i] <= LEVEL_FULL;
      target_on    <= '1;
      mode_bit     <= 1'b0;
      solid_color  <= COLOR_FIRST;
      speed_level  <= 2'd0;
      prev_buttons <= BTN_IDLE;
      pin_reg      <= '0;
    end else if (accept) begin
      pwm_counter  <= pwm_counter_next;
      level        <= level_next;
      target_on    <= target_on_next;
      mode_bit     <= mode_bit_next;
      solid_color  <= solid_color_next;
      speed_level  <= speed_level_next;
      prev_buttons <= prev_buttons_next;
      pin_reg      <= pin_reg_next;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid || pop) result_valid <= 1'b1;
      else                      skid_valid   <= 1'b1;
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) result <= skid;
    end else if (accept) begin
      if (!result_valid || pop) result <= fresh;
      else                      skid   <= fresh;
    end
  end

  // Checks
  `RLF_ASSERT_IMPL(a_skid_behind_main, clk, rst, skid_valid, result_valid)
  `RLF_ASSERT_IMPL(a_color_nonzero, clk, rst, 1'b1, solid_color != 3'd0)
  `RLF_ASSERT_IMPL(a_speed_range, clk, rst, 1'b1, speed_level != 2'd3)
  `RLF_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && pop, !skid_valid && result_valid)

endmodule
